// ----- design/lzc_pkg.sv -----
// Shared types and constants of the LZ77 image line compressor.
package lzc_pkg;

  localparam int MIN_MATCH = 3;
  localparam logic [7:0] LIT_BIAS = 8'd127;

  typedef enum logic [4:0] {
    S_IDLE, S_CLR, S_WRITE, S_PROC, S_TOK, S_INSCHK,
    S_HS0, S_HS1, S_HS2, S_HS3,
    S_INS_CLR, S_INS_HEAD, S_INS_LINK, S_INS_FIN,
    S_TOK_HEAD, S_TOK_N, S_WALK, S_CMP0, S_CMP,
    S_DECIDE, S_LIT_WR, S_MATCH0, S_MATCH1, S_ADV,
    S_FL_CHK, S_FL_HDR, S_FL_BYTE, S_END, S_END2, S_POST
  } lzc_state_t;

  typedef enum logic [1:0] {FR_LIT, FR_MATCH, FR_END} lzc_fret_t;

  typedef struct packed {
    logic       emit;
    logic [7:0] data;
    logic       close;
  } lzc_pk_ctl_t;

  typedef struct packed {
    logic emit_ok;
    logic close_ok;
    logic empty;
  } lzc_pk_sts_t;

endpackage

// ----- design/lzc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module lzc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/lzc_pack.sv -----
// Byte packer that groups coded bytes four to a result and holds the output register.
module lzc_pack (
  input  logic                 clk,
  input  logic                 rst,
  input  lzc_pkg::lzc_pk_ctl_t ctl,
  output lzc_pkg::lzc_pk_sts_t sts,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_byte_0,
  output logic [7:0]           out_byte_1,
  output logic [7:0]           out_byte_2,
  output logic [7:0]           out_byte_3,
  output logic [2:0]           byte_count,
  output logic                 line_finished
);
  import lzc_pkg::*;

  logic [7:0] pack [4];
  logic [2:0] pack_n;
  logic       out_free;
  logic       full;
  logic       load;
  logic       load_last;

  assign out_free     = !out_valid || out_ready;
  assign full         = (pack_n == 3'd4);
  assign sts.emit_ok  = !full || out_free;
  assign sts.close_ok = out_free;
  assign sts.empty    = (pack_n == 3'd0);
  assign load_last    = ctl.close && out_free;
  assign load         = (ctl.emit && full && out_free) || load_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pack_n    <= 3'd0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (ctl.emit && sts.emit_ok) begin
        pack_n <= full ? 3'd1 : pack_n + 3'd1;
      end else if (load_last) begin
        pack_n <= 3'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit && sts.emit_ok) begin
      if (full) begin
        pack[0] <= ctl.data;
      end else begin
        pack[pack_n[1:0]] <= ctl.data;
      end
    end
    if (load) begin
      out_byte_0    <= (pack_n > 3'd0) ? pack[0] : 8'd0;
      out_byte_1    <= (pack_n > 3'd1) ? pack[1] : 8'd0;
      out_byte_2    <= (pack_n > 3'd2) ? pack[2] : 8'd0;
      out_byte_3    <= (pack_n > 3'd3) ? pack[3] : 8'd0;
      byte_count    <= pack_n;
      line_finished <= load_last;
    end
  end

endmodule

// ----- design/lz77_image_line_compressor.sv -----
// Top level of the LZ77 image line compressor: sequencer, hash chains and history memories.
// The block takes one image byte per item and returns coded bytes packed up to four per
// result, with line_finished on the last result of each line. Work runs on one sequencer
// that reads the history memory one byte per cycle: each chain insertion hashes three
// bytes and updates heads, links and back pointers, hashing the cursor reads three bytes,
// and each chain candidate is compared byte by byte, so an item may be only buffered or
// may need a long chain walk. After reset, after a restart item and after an end-of-image
// item the hash chains are cleared, all max(2^(3*HASH_SHIFT), WINDOW_SIZE) entries (1024
// at the defaults), and no item is accepted during the clear.
module lz77_image_line_compressor #(
  parameter int MAX_RUN     = 34,
  parameter int LITERAL_MAX = 128,
  parameter int WINDOW_SIZE = 1024,
  parameter int HASH_SHIFT  = 3
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       end_of_line,
  input  logic       end_of_image,
  input  logic       restart,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte_0,
  output logic [7:0] out_byte_1,
  output logic [7:0] out_byte_2,
  output logic [7:0] out_byte_3,
  output logic [2:0] byte_count,
  output logic       line_finished
);
  import lzc_pkg::*;

  localparam int WB    = $clog2(WINDOW_SIZE);
  localparam int NB    = $clog2(WINDOW_SIZE + 1);
  localparam int PW    = WB + 1;
  localparam int RING  = 1 << PW;
  localparam int HB    = MIN_MATCH * HASH_SHIFT;
  localparam int NHASH = 1 << HB;
  localparam int HSW   = HB + 8;
  localparam int VW    = (HB > NB) ? HB : NB;
  localparam int BLW   = VW + 1;
  localparam int RB    = $clog2(MAX_RUN + 1);
  localparam int LB    = $clog2(LITERAL_MAX + 1);
  localparam int LIW   = (LITERAL_MAX > 1) ? $clog2(LITERAL_MAX) : 1;
  localparam int CN    = (NHASH > WINDOW_SIZE) ? NHASH : WINDOW_SIZE;
  localparam int CB    = $clog2(CN);

  lzc_state_t state, state_next;
  lzc_fret_t  fl_ret;

  logic [CB-1:0]  cc;
  logic           eol_pending, pre, clr_to_write, ins_ret, for_ins;
  logic [LB-1:0]  lit_count;
  logic [7:0]     in_d;
  logic           in_eol, in_eoi;
  logic [PW-1:0]  arrive, cur, ins, hpos, best, q;
  logic [WB-1:0]  wp, node;
  logic [RB-1:0]  span, runlen, lc;
  logic [NB-1:0]  n, old;
  logic [7:0]     b0, b1;
  logic [BLW-1:0] bl;
  logic [HB-1:0]  h;
  logic [LIW-1:0] fi;

  logic           in_acc, at_end, short_wait, ins_go, walk_go, cmp_go, fi_last, last_clr;
  logic [PW-1:0]  avail, offs, q_calc;
  logic [RB-1:0]  span_calc;
  logic [HSW-1:0] hsum;
  logic [HB-1:0]  h_calc;
  logic [PW-1:0]  age_t, age_w;
  logic [WB-1:0]  node_calc, wp_inc;
  logic [NB-1:0]  wp_ref;
  logic [15:0]    hdr_w;

  logic [PW-1:0]  ring_a_ra, ring_b_ra;
  logic [7:0]     ring_a_q, ring_b_q;
  logic           ring_we;
  logic           heads_we, links_we, back_we, lit_we;
  logic [HB-1:0]  heads_wa;
  logic [NB-1:0]  heads_wd, heads_q, links_wd, links_q;
  logic [WB-1:0]  links_wa, back_wa;
  logic [BLW-1:0] back_wd, back_q;
  logic [LIW-1:0] lit_ra;
  logic [7:0]     lit_q;

  lzc_pk_ctl_t pk_ctl;
  lzc_pk_sts_t pk_sts;

  assign in_ready   = (state == S_IDLE);
  assign in_acc     = in_valid && in_ready;
  assign avail      = arrive - cur;
  assign at_end     = (cur == arrive);
  assign short_wait = !eol_pending && (avail < PW'(MAX_RUN));
  assign span_calc  = (avail < PW'(MAX_RUN)) ? RB'(avail) : RB'(MAX_RUN);
  assign ins_go     = (ins != cur) && ((arrive - ins) >= PW'(MIN_MATCH));
  assign walk_go    = (n != '0) && (runlen < span);
  assign cmp_go     = (lc < span) && (ring_a_q == ring_b_q);
  assign fi_last    = (fi == LIW'(lit_count - LB'(1)));
  assign last_clr   = (cc == CB'(CN - 1));

  assign hsum   = (HSW'(b0) << (2 * HASH_SHIFT)) ^ (HSW'(b1) << HASH_SHIFT) ^ HSW'(ring_a_q);
  assign h_calc = hsum[HB-1:0];

  assign node_calc = WB'(n - NB'(1));
  assign age_t     = PW'(wp) + PW'(WINDOW_SIZE) - PW'(node_calc) - PW'(1);
  assign age_w     = ((age_t >= PW'(WINDOW_SIZE)) ? age_t - PW'(WINDOW_SIZE) : age_t) + PW'(1);
  assign q_calc    = ins - age_w;
  assign wp_inc    = (wp == WB'(WINDOW_SIZE - 1)) ? '0 : wp + WB'(1);
  assign wp_ref    = NB'(wp) + NB'(1);
  assign offs      = cur - best - PW'(1);
  assign hdr_w     = ((16'(runlen) - 16'(MIN_MATCH)) << 2) + 16'(offs >> 8);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLR;
      cc           <= '0;
      eol_pending  <= 1'b0;
      lit_count    <= '0;
      pre          <= 1'b0;
      clr_to_write <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          if (in_acc && restart && !at_end) begin
            eol_pending <= 1'b1;
            pre         <= 1'b1;
          end else if (in_acc && restart) begin
            clr_to_write <= 1'b1;
          end
        end
        S_CLR: cc <= last_clr ? '0 : cc + CB'(1);
        S_WRITE: begin
          if (in_eol || in_eoi) begin
            eol_pending <= 1'b1;
          end
        end
        S_LIT_WR: begin
          if (lit_count < LB'(LITERAL_MAX)) begin
            lit_count <= lit_count + LB'(1);
          end
        end
        S_FL_BYTE: begin
          if (pk_sts.emit_ok && fi_last) begin
            lit_count <= '0;
          end
        end
        S_END2: begin
          if (pk_sts.empty || pk_sts.close_ok) begin
            eol_pending <= 1'b0;
          end
        end
        S_POST: begin
          pre          <= 1'b0;
          clr_to_write <= pre;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          in_d   <= data_byte;
          in_eol <= end_of_line;
          in_eoi <= end_of_image;
        end
      end
      S_CLR: begin
        if (last_clr) begin
          arrive <= '0;
          cur    <= '0;
          ins    <= '0;
          wp     <= '0;
        end
      end
      S_WRITE: arrive <= arrive + PW'(1);
      S_PROC:  span <= span_calc;
      S_TOK: begin
        runlen  <= '0;
        ins_ret <= 1'b1;
      end
      S_INSCHK: begin
        hpos    <= ins_go ? ins : cur;
        for_ins <= ins_go;
      end
      S_HS1: begin
        b0 <= ring_a_q;
        bl <= back_q;
      end
      S_HS2:      b1 <= ring_a_q;
      S_HS3:      h <= h_calc;
      S_INS_LINK: old <= heads_q;
      S_INS_FIN: begin
        wp  <= wp_inc;
        ins <= ins + PW'(1);
      end
      S_TOK_N: begin
        n      <= heads_q;
        runlen <= '0;
      end
      S_WALK: begin
        node <= node_calc;
        q    <= q_calc;
      end
      S_CMP0: lc <= '0;
      S_CMP: begin
        if (cmp_go) begin
          lc <= lc + RB'(1);
        end else begin
          if (lc > runlen) begin
            runlen <= lc;
            best   <= q;
          end
          n <= links_q;
        end
      end
      S_DECIDE: fl_ret <= FR_MATCH;
      S_LIT_WR: begin
        fl_ret <= FR_LIT;
        if (lit_count < LB'(LITERAL_MAX)) begin
          runlen <= RB'(1);
        end
      end
      S_ADV: begin
        cur     <= cur + PW'(runlen);
        ins_ret <= 1'b0;
      end
      S_FL_HDR: fi <= '0;
      S_FL_BYTE: begin
        if (pk_sts.emit_ok && !fi_last) begin
          fi <= fi + LIW'(1);
        end
      end
      S_END: fl_ret <= FR_END;
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    pk_ctl     = '0;
    ring_a_ra  = cur;
    ring_b_ra  = q;
    lit_ra     = '0;
    ring_we    = 1'b0;
    heads_we   = 1'b0;
    heads_wa   = h;
    heads_wd   = '0;
    links_we   = 1'b0;
    links_wa   = wp;
    links_wd   = '0;
    back_we    = 1'b0;
    back_wa    = wp;
    back_wd    = '0;
    lit_we     = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          if (restart) begin
            state_next = at_end ? S_CLR : S_PROC;
          end else begin
            state_next = S_WRITE;
          end
        end
      end
      S_CLR: begin
        heads_we = (32'(cc) < NHASH);
        heads_wa = cc[HB-1:0];
        links_we = (32'(cc) < WINDOW_SIZE);
        links_wa = cc[WB-1:0];
        back_we  = links_we;
        back_wa  = cc[WB-1:0];
        if (last_clr) begin
          state_next = clr_to_write ? S_WRITE : S_IDLE;
        end
      end
      S_WRITE: begin
        ring_we    = 1'b1;
        state_next = S_PROC;
      end
      S_PROC: begin
        if (at_end || short_wait) begin
          state_next = S_END;
        end else begin
          state_next = S_TOK;
        end
      end
      S_TOK:    state_next = (span >= RB'(MIN_MATCH)) ? S_INSCHK : S_DECIDE;
      S_INSCHK: state_next = (ins_go || ins_ret) ? S_HS0 : S_PROC;
      S_HS0: begin
        ring_a_ra  = hpos;
        state_next = S_HS1;
      end
      S_HS1: begin
        ring_a_ra  = hpos + PW'(1);
        state_next = S_HS2;
      end
      S_HS2: begin
        ring_a_ra  = hpos + PW'(2);
        state_next = S_HS3;
      end
      S_HS3: state_next = for_ins ? S_INS_CLR : S_TOK_HEAD;
      S_INS_CLR: begin
        if (bl != '0) begin
          heads_we = bl[BLW-1];
          heads_wa = bl[HB-1:0];
          links_we = !bl[BLW-1];
          links_wa = WB'(bl[VW-1:0] - VW'(1));
        end
        state_next = S_INS_HEAD;
      end
      S_INS_HEAD: state_next = S_INS_LINK;
      S_INS_LINK: begin
        links_we   = 1'b1;
        links_wd   = heads_q;
        back_we    = 1'b1;
        back_wd    = {1'b1, VW'(h)};
        state_next = S_INS_FIN;
      end
      S_INS_FIN: begin
        heads_we   = 1'b1;
        heads_wd   = wp_ref;
        back_we    = (old != '0);
        back_wa    = WB'(old - NB'(1));
        back_wd    = {1'b0, VW'(wp_ref)};
        state_next = S_INSCHK;
      end
      S_TOK_HEAD: state_next = S_TOK_N;
      S_TOK_N:    state_next = S_WALK;
      S_WALK:     state_next = walk_go ? S_CMP0 : S_DECIDE;
      S_CMP0:     state_next = S_CMP;
      S_CMP: begin
        ring_a_ra = cur + PW'(lc) + PW'(1);
        ring_b_ra = q + PW'(lc) + PW'(1);
        if (!cmp_go) begin
          state_next = S_WALK;
        end
      end
      S_DECIDE: state_next = (runlen < RB'(MIN_MATCH)) ? S_LIT_WR : S_FL_CHK;
      S_LIT_WR: begin
        if (lit_count >= LB'(LITERAL_MAX)) begin
          state_next = S_FL_CHK;
        end else begin
          lit_we     = 1'b1;
          state_next = S_ADV;
        end
      end
      S_MATCH0: begin
        pk_ctl.emit = 1'b1;
        pk_ctl.data = hdr_w[7:0];
        if (pk_sts.emit_ok) begin
          state_next = S_MATCH1;
        end
      end
      S_MATCH1: begin
        pk_ctl.emit = 1'b1;
        pk_ctl.data = 8'(offs);
        if (pk_sts.emit_ok) begin
          state_next = S_ADV;
        end
      end
      S_ADV: state_next = S_INSCHK;
      S_FL_CHK: begin
        if (lit_count != '0) begin
          state_next = S_FL_HDR;
        end else begin
          case (fl_ret)
            FR_LIT:   state_next = S_LIT_WR;
            FR_MATCH: state_next = S_MATCH0;
            FR_END:   state_next = S_END2;
            default:  state_next = S_IDLE;
          endcase
        end
      end
      S_FL_HDR: begin
        pk_ctl.emit = 1'b1;
        pk_ctl.data = 8'(8'(lit_count) + LIT_BIAS);
        if (pk_sts.emit_ok) begin
          state_next = S_FL_BYTE;
        end
      end
      S_FL_BYTE: begin
        pk_ctl.emit = 1'b1;
        pk_ctl.data = lit_q;
        lit_ra      = pk_sts.emit_ok ? fi + LIW'(1) : fi;
        if (pk_sts.emit_ok && fi_last) begin
          case (fl_ret)
            FR_LIT:   state_next = S_LIT_WR;
            FR_MATCH: state_next = S_MATCH0;
            FR_END:   state_next = S_END2;
            default:  state_next = S_IDLE;
          endcase
        end
      end
      S_END: state_next = (eol_pending && at_end) ? S_FL_CHK : S_POST;
      S_END2: begin
        pk_ctl.close = !pk_sts.empty;
        if (pk_sts.empty || pk_sts.close_ok) begin
          state_next = S_POST;
        end
      end
      S_POST: state_next = (pre || in_eoi) ? S_CLR : S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  lzc_ram #(.WIDTH(8), .DEPTH(RING)) u_ring_a (
    .clk(clk), .we(ring_we), .waddr(arrive), .wdata(in_d), .raddr(ring_a_ra), .rdata(ring_a_q)
  );

  lzc_ram #(.WIDTH(8), .DEPTH(RING)) u_ring_b (
    .clk(clk), .we(ring_we), .waddr(arrive), .wdata(in_d), .raddr(ring_b_ra), .rdata(ring_b_q)
  );

  lzc_ram #(.WIDTH(NB), .DEPTH(NHASH)) u_heads (
    .clk(clk), .we(heads_we), .waddr(heads_wa), .wdata(heads_wd), .raddr(h), .rdata(heads_q)
  );

  lzc_ram #(.WIDTH(NB), .DEPTH(WINDOW_SIZE)) u_links (
    .clk(clk), .we(links_we), .waddr(links_wa), .wdata(links_wd), .raddr(node),
    .rdata(links_q)
  );

  lzc_ram #(.WIDTH(BLW), .DEPTH(WINDOW_SIZE)) u_back (
    .clk(clk), .we(back_we), .waddr(back_wa), .wdata(back_wd), .raddr(wp), .rdata(back_q)
  );

  lzc_ram #(.WIDTH(8), .DEPTH(LITERAL_MAX)) u_lit (
    .clk(clk), .we(lit_we), .waddr(lit_count[LIW-1:0]), .wdata(ring_a_q), .raddr(lit_ra),
    .rdata(lit_q)
  );

  lzc_pack u_pack (
    .clk(clk),
    .rst(rst),
    .ctl(pk_ctl),
    .sts(pk_sts),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_byte_0(out_byte_0),
    .out_byte_1(out_byte_1),
    .out_byte_2(out_byte_2),
    .out_byte_3(out_byte_3),
    .byte_count(byte_count),
    .line_finished(line_finished)
  );

endmodule

// ----- design/lzc_check.sv -----
// Port-level checks of the compressor, attached to the top level by bind.
module lzc_check (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte_0,
  input logic [7:0] out_byte_1,
  input logic [7:0] out_byte_2,
  input logic [7:0] out_byte_3,
  input logic [2:0] byte_count,
  input logic       line_finished
);

  // A stalled result keeps its contents.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(byte_count) && $stable(out_byte_0)
      && $stable(out_byte_3) && $stable(line_finished))
    else $error("stalled result changed");

  // Only the last result of a line may carry fewer than four bytes.
  a_partial: assert property (@(posedge clk) disable iff (rst)
    out_valid && !line_finished |-> byte_count == 3'd4)
    else $error("partial result not at line end");

  a_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> byte_count != 3'd0 && byte_count <= 3'd4)
    else $error("byte count out of range");

  // Bytes past the count are zero.
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (byte_count == 3'd4 || out_byte_3 == 8'd0)
      && (byte_count >= 3'd3 || out_byte_2 == 8'd0)
      && (byte_count >= 3'd2 || out_byte_1 == 8'd0))
    else $error("unused result byte not zero");

  // No item is accepted in the cycle after an accepted item.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted on consecutive cycles");

endmodule

bind lz77_image_line_compressor lzc_check u_check (
  .clk(clk),
  .rst(rst),
  .in_valid(in_valid),
  .in_ready(in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_byte_0(out_byte_0),
  .out_byte_1(out_byte_1),
  .out_byte_2(out_byte_2),
  .out_byte_3(out_byte_3),
  .byte_count(byte_count),
  .line_finished(line_finished)
);
